// File: hw/rtl/trs_model_matrix_unit_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms for the model matrix unit
// ------------------------------------------------------------------------
`ifndef TRS_MODEL_MATRIX_UNIT_MACROS_SVH
`define TRS_MODEL_MATRIX_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define TMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tmm check failed");

// next-cycle implication, off during reset
`define TMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tmm check failed");

`endif

// File: hw/rtl/tmm_pkg.sv
// ------------------------------------------------------------------------
// tmm_pkg
// shared constants and types of the model matrix unit
// ------------------------------------------------------------------------
package tmm_pkg;

	localparam int CORDIC_STEPS_DEF = 18;
	localparam int TABLE_LEN        = 30;
	localparam int LANES            = 3;
	localparam int ROT_TERMS        = 9;
	localparam int GROUPS           = 4;

	localparam logic [1:0] LAST_GROUP = 2'd3;

	localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
	localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
	localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q16  = 32'sd65536;

	typedef logic signed [15:0] angle_t;
	typedef logic signed [31:0] q_t;

	// arctangent of 2^-i in degrees, Q8.24
	localparam logic signed [33:0] ATAN_Q24 [TABLE_LEN] = '{
		34'sd754974720, 34'sd445687602, 34'sd235489089, 34'sd119537938,
		34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
		34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
		34'sd234684, 34'sd117342, 34'sd58671, 34'sd29335,
		34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
		34'sd917, 34'sd458, 34'sd229, 34'sd115,
		34'sd57, 34'sd29, 34'sd14, 34'sd7,
		34'sd4, 34'sd2
	};

endpackage

// File: hw/rtl/tmm_cordic.sv
// ------------------------------------------------------------------------
// tmm_cordic
// angle reduction and pipelined cordic, three lanes side by side
// ------------------------------------------------------------------------
module tmm_cordic #(
	parameter int CORDIC_STEPS = tmm_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  tmm_pkg::angle_t angle [tmm_pkg::LANES],
	output logic            vld_out,
	output tmm_pkg::q_t     sin_o [tmm_pkg::LANES],
	output tmm_pkg::q_t     cos_o [tmm_pkg::LANES]
);

	logic              vld_s  [CORDIC_STEPS+1];
	logic              flip_s [CORDIC_STEPS+1][tmm_pkg::LANES];
	tmm_pkg::q_t       cx_s   [CORDIC_STEPS+1][tmm_pkg::LANES];
	tmm_pkg::q_t       cy_s   [CORDIC_STEPS+1][tmm_pkg::LANES];
	logic signed [33:0] cz_s  [CORDIC_STEPS+1][tmm_pkg::LANES];

	logic signed [16:0] red   [tmm_pkg::LANES];
	logic               fold  [tmm_pkg::LANES];

	// reduce to one turn, center, fold into a quarter turn either side
	always_comb begin
		logic signed [16:0] m;
		for (int l = 0; l < tmm_pkg::LANES; l++) begin
			m = 17'(angle[l]);
			if (m >= tmm_pkg::FULL_TURN) begin
				m = m - tmm_pkg::FULL_TURN;
			end else if (m < 17'sd0) begin
				m = m + tmm_pkg::FULL_TURN;
				if (m < 17'sd0) begin
					m = m + tmm_pkg::FULL_TURN;
				end
			end
			if (m >= tmm_pkg::HALF_TURN) begin
				m = m - tmm_pkg::FULL_TURN;
			end
			fold[l] = 1'b0;
			if (m > tmm_pkg::QUARTER_TURN) begin
				m = m - tmm_pkg::HALF_TURN;
				fold[l] = 1'b1;
			end else if (m < -tmm_pkg::QUARTER_TURN) begin
				m = m + tmm_pkg::HALF_TURN;
				fold[l] = 1'b1;
			end
			red[l] = m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= CORDIC_STEPS; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int s = 1; s <= CORDIC_STEPS; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < tmm_pkg::LANES; l++) begin
				flip_s[0][l] <= fold[l];
				cx_s[0][l]   <= tmm_pkg::GAIN_Q30;
				cy_s[0][l]   <= '0;
				cz_s[0][l]   <= 34'(red[l]) <<< 18;
			end
		end
	end

	for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < tmm_pkg::LANES; l++) begin
					flip_s[gi+1][l] <= flip_s[gi][l];
					if (cz_s[gi][l] >= 34'sd0) begin
						cx_s[gi+1][l] <= cx_s[gi][l] - (cy_s[gi][l] >>> gi);
						cy_s[gi+1][l] <= cy_s[gi][l] + (cx_s[gi][l] >>> gi);
						cz_s[gi+1][l] <= cz_s[gi][l] - tmm_pkg::ATAN_Q24[gi];
					end else begin
						cx_s[gi+1][l] <= cx_s[gi][l] + (cy_s[gi][l] >>> gi);
						cy_s[gi+1][l] <= cy_s[gi][l] - (cx_s[gi][l] >>> gi);
						cz_s[gi+1][l] <= cz_s[gi][l] + tmm_pkg::ATAN_Q24[gi];
					end
				end
			end
		end
	end

	assign vld_out = vld_s[CORDIC_STEPS];

	always_comb begin
		for (int l = 0; l < tmm_pkg::LANES; l++) begin
			sin_o[l] = flip_s[CORDIC_STEPS][l] ? -cy_s[CORDIC_STEPS][l] : cy_s[CORDIC_STEPS][l];
			cos_o[l] = flip_s[CORDIC_STEPS][l] ? -cx_s[CORDIC_STEPS][l] : cx_s[CORDIC_STEPS][l];
		end
	end

endmodule

// File: hw/rtl/tmm_matrix.sv
// ------------------------------------------------------------------------
// tmm_matrix
// rotation terms, scale multiply, rounding and saturation in four stages
// ------------------------------------------------------------------------
module tmm_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  tmm_pkg::q_t sin_i   [tmm_pkg::LANES],
	input  tmm_pkg::q_t cos_i   [tmm_pkg::LANES],
	input  tmm_pkg::q_t scale_i,
	input  tmm_pkg::q_t shift_i [tmm_pkg::LANES],
	output logic        vld_out,
	output tmm_pkg::q_t ent_o   [tmm_pkg::ROT_TERMS],
	output tmm_pkg::q_t shift_o [tmm_pkg::LANES]
);

	// q30 product rounded to nearest
	function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
	                                              input logic signed [32:0] b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b) + 66'sd536870912;
		return p[62:30];
	endfunction

	function automatic tmm_pkg::q_t sat32(input logic signed [35:0] v);
		tmm_pkg::q_t r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// lanes: 0 = a (z), 1 = b (y), 2 = c (x)
	logic signed [32:0] sasb_s1, casb_s1, cbcc_s1, cbsc_s1, nsb_s1;
	logic signed [32:0] sasc_s1, sacc_s1, cacc_s1, casc_s1, sacb_s1, cacb_s1;
	logic signed [32:0] cc_s1, sc_s1;
	logic signed [33:0] rot_s2  [tmm_pkg::ROT_TERMS];
	logic signed [65:0] prod_s3 [tmm_pkg::ROT_TERMS];
	tmm_pkg::q_t        ent_s4  [tmm_pkg::ROT_TERMS];
	tmm_pkg::q_t        scale_s1, scale_s2;
	tmm_pkg::q_t        sh_s1 [tmm_pkg::LANES];
	tmm_pkg::q_t        sh_s2 [tmm_pkg::LANES];
	tmm_pkg::q_t        sh_s3 [tmm_pkg::LANES];
	tmm_pkg::q_t        sh_s4 [tmm_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [36:0] rnd;
		if (en) begin
			// first products
			sasb_s1  <= mul_q30(33'(sin_i[0]), 33'(sin_i[1]));
			casb_s1  <= mul_q30(33'(cos_i[0]), 33'(sin_i[1]));
			cbcc_s1  <= mul_q30(33'(cos_i[1]), 33'(cos_i[2]));
			cbsc_s1  <= mul_q30(33'(cos_i[1]), 33'(sin_i[2]));
			sasc_s1  <= mul_q30(33'(sin_i[0]), 33'(sin_i[2]));
			sacc_s1  <= mul_q30(33'(sin_i[0]), 33'(cos_i[2]));
			cacc_s1  <= mul_q30(33'(cos_i[0]), 33'(cos_i[2]));
			casc_s1  <= mul_q30(33'(cos_i[0]), 33'(sin_i[2]));
			sacb_s1  <= mul_q30(33'(sin_i[0]), 33'(cos_i[1]));
			cacb_s1  <= mul_q30(33'(cos_i[0]), 33'(cos_i[1]));
			nsb_s1   <= -33'(sin_i[1]);
			cc_s1    <= 33'(cos_i[2]);
			sc_s1    <= 33'(sin_i[2]);
			scale_s1 <= scale_i;
			sh_s1    <= shift_i;

			// second products and sums
			rot_s2[0] <= 34'(cbcc_s1);
			rot_s2[1] <= 34'(cbsc_s1);
			rot_s2[2] <= 34'(nsb_s1);
			rot_s2[3] <= 34'(mul_q30(sasb_s1, cc_s1)) - 34'(casc_s1);
			rot_s2[4] <= 34'(mul_q30(sasb_s1, sc_s1)) + 34'(cacc_s1);
			rot_s2[5] <= 34'(sacb_s1);
			rot_s2[6] <= 34'(mul_q30(casb_s1, cc_s1)) + 34'(sasc_s1);
			rot_s2[7] <= 34'(mul_q30(casb_s1, sc_s1)) - 34'(sacc_s1);
			rot_s2[8] <= 34'(cacb_s1);
			scale_s2  <= scale_s1;
			sh_s2     <= sh_s1;

			// scale multiply
			for (int j = 0; j < tmm_pkg::ROT_TERMS; j++) begin
				prod_s3[j] <= 66'(rot_s2[j]) * 66'(scale_s2);
			end
			sh_s3 <= sh_s2;

			// round and saturate
			for (int j = 0; j < tmm_pkg::ROT_TERMS; j++) begin
				rnd = 37'((prod_s3[j] + 66'sd536870912) >>> 30);
				ent_s4[j] <= sat32(rnd[35:0]);
			end
			sh_s4 <= sh_s3;
		end
	end

	assign vld_out = vld_s4;
	assign ent_o   = ent_s4;
	assign shift_o = sh_s4;

endmodule

// File: hw/rtl/tmm_serial.sv
// ------------------------------------------------------------------------
// tmm_serial
// holds one finished matrix and sends it as four column groups
// ------------------------------------------------------------------------
module tmm_serial (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tmm_pkg::q_t   ent_i   [tmm_pkg::ROT_TERMS],
	input  tmm_pkg::q_t   shift_i [tmm_pkg::LANES],
	output logic          free,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata,
	output logic [1:0]    m_axis_tuser,
	output logic          m_axis_tlast
);

	logic        full_q;
	logic [1:0]  grp_q;
	tmm_pkg::q_t ent_q [tmm_pkg::ROT_TERMS];
	tmm_pkg::q_t sh_q  [tmm_pkg::LANES];
	logic        done;

	assign done = m_axis_tready && (grp_q == tmm_pkg::LAST_GROUP);
	assign free = !full_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			grp_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			grp_q  <= '0;
		end else if (full_q && m_axis_tready) begin
			if (grp_q == tmm_pkg::LAST_GROUP) begin
				full_q <= 1'b0;
			end
			grp_q <= grp_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= ent_i;
			sh_q  <= shift_i;
		end
	end

	always_comb begin
		unique case (grp_q)
			2'd0: m_axis_tdata = {32'd0, ent_q[2], ent_q[1], ent_q[0]};
			2'd1: m_axis_tdata = {32'd0, ent_q[5], ent_q[4], ent_q[3]};
			2'd2: m_axis_tdata = {32'd0, ent_q[8], ent_q[7], ent_q[6]};
			default: m_axis_tdata = {tmm_pkg::ONE_Q16, sh_q[2], sh_q[1], sh_q[0]};
		endcase
	end

	assign m_axis_tvalid = full_q;
	assign m_axis_tuser  = grp_q;
	assign m_axis_tlast  = (grp_q == tmm_pkg::LAST_GROUP);

endmodule

// File: hw/rtl/trs_model_matrix_unit.sv
// ------------------------------------------------------------------------
// trs_model_matrix_unit
// euler angle rotate, scale and translate model matrix
// ------------------------------------------------------------------------
// Each input item brings three angles in degrees (Q9.6), a uniform scale and
// a translation (Q16.16). The block answers with the column-major 4x4 model
// matrix as four output items of four Q16.16 entries, tuser giving the
// column group and tlast marking the fourth. Every angle is reduced to one
// turn and folded to a quarter turn, then its sine and cosine come from a
// CORDIC pipeline of CORDIC_STEPS stages; four more stages form the rotation
// terms, multiply by the scale and round with saturation. The pipeline takes
// an item every cycle while it is not stalled, but the single output channel
// sends each matrix as four groups, so the sustained rate is set by the output
// serializer. Back-pressure on the output freezes the whole pipeline once a
// finished matrix waits at its end.

`include "trs_model_matrix_unit_macros.svh"

module trs_model_matrix_unit #(
	parameter int CORDIC_STEPS = tmm_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// angle_z, angle_y, angle_x, scale_factor, shift_x, shift_y, shift_z
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// entry_first, entry_second, entry_third, entry_fourth
	output logic [127:0] m_axis_tdata,
	// group_index
	output logic [1:0]   m_axis_tuser,
	// last_group
	output logic         m_axis_tlast
);

	// global advance: the whole pipeline moves together
	logic adv;
	logic accept;

	tmm_pkg::angle_t angle [tmm_pkg::LANES];
	tmm_pkg::q_t     sin_v [tmm_pkg::LANES];
	tmm_pkg::q_t     cos_v [tmm_pkg::LANES];
	logic            cor_vld;

	// scale and translation ride alongside the cordic stages
	tmm_pkg::q_t scale_q [CORDIC_STEPS+1];
	tmm_pkg::q_t shx_q   [CORDIC_STEPS+1];
	tmm_pkg::q_t shy_q   [CORDIC_STEPS+1];
	tmm_pkg::q_t shz_q   [CORDIC_STEPS+1];
	tmm_pkg::q_t shift_v [tmm_pkg::LANES];

	logic        mat_vld;
	tmm_pkg::q_t ent   [tmm_pkg::ROT_TERMS];
	tmm_pkg::q_t shout [tmm_pkg::LANES];
	logic        ser_free;

	assign adv           = !mat_vld || ser_free;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// lane 0 is angle a (z), lane 1 is b (y), lane 2 is c (x)
	assign angle[0] = s_axis_tdata[15:0];
	assign angle[1] = s_axis_tdata[31:16];
	assign angle[2] = s_axis_tdata[47:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			scale_q[0] <= s_axis_tdata[79:48];
			shx_q[0]   <= s_axis_tdata[111:80];
			shy_q[0]   <= s_axis_tdata[143:112];
			shz_q[0]   <= s_axis_tdata[175:144];
			for (int s = 1; s <= CORDIC_STEPS; s++) begin
				scale_q[s] <= scale_q[s-1];
				shx_q[s]   <= shx_q[s-1];
				shy_q[s]   <= shy_q[s-1];
				shz_q[s]   <= shz_q[s-1];
			end
		end
	end

	assign shift_v[0] = shx_q[CORDIC_STEPS];
	assign shift_v[1] = shy_q[CORDIC_STEPS];
	assign shift_v[2] = shz_q[CORDIC_STEPS];

	tmm_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (accept),
		.angle   (angle),
		.vld_out (cor_vld),
		.sin_o   (sin_v),
		.cos_o   (cos_v)
	);

	tmm_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (cor_vld),
		.sin_i   (sin_v),
		.cos_i   (cos_v),
		.scale_i (scale_q[CORDIC_STEPS]),
		.shift_i (shift_v),
		.vld_out (mat_vld),
		.ent_o   (ent),
		.shift_o (shout)
	);

	// output register: takes a finished matrix while the pipeline keeps going
	tmm_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (mat_vld && ser_free),
		.ent_i         (ent),
		.shift_i       (shout),
		.free          (ser_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// tlast marks exactly the fourth group
	`TMM_ASSERT_NOW(a_last_grp, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == tmm_pkg::LAST_GROUP)
	// a matrix is never cut short
	`TMM_ASSERT_NEXT(a_no_cut, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
	// groups go out in order
	`TMM_ASSERT_NEXT(a_grp_order, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tuser == $past(m_axis_tuser) + 2'd1)

endmodule
